/* hdl/qjt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package qjt_pkg;

    // Default number of joint store entries.
    localparam int MAX_JOINTS_DEF = 8;

    // Divider geometry: dividend and quotient width, divisor width.
    localparam int DIV_W  = 64;
    localparam int DIVS_W = 25;

    // Move timing limits in microseconds.
    localparam logic [24:0] DUR_MIN_US   = 25'd50000;
    localparam logic [24:0] DUR_MAX_US   = 25'd30000000;
    localparam logic [24:0] DUR_RESET_US = 25'd50000;
    localparam int          STEP_MAX_US  = 100000;
    localparam logic [16:0] STEP_DEF_US  = 17'd1000;

    // Speed ratio limits in Q1.16.
    localparam logic [16:0] RATIO_MIN   = 17'd655;
    localparam logic [16:0] RATIO_MAX   = 17'd65536;
    localparam logic [16:0] RATIO_RESET = 17'd65536;
    localparam logic [3:0]  JCNT_RESET  = 4'd6;

    // Arithmetic constants.
    localparam logic signed [31:0] US_PER_S = 32'sd1000000;
    localparam logic signed [15:0] CM_K     = 16'sd15625;
    localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_SPEED_RATIO = 1'b0,
        REG_JOINT_COUNT = 1'b1
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_DIV,
        ST_LD_WAIT,
        ST_TK_STEP,
        ST_TK_DIV,
        ST_TK_WAIT,
        ST_TK_P2,
        ST_TK_P3,
        ST_TK_P4,
        ST_TK_P5,
        ST_TK_POLY,
        ST_J_RD,
        ST_J_DELTA,
        ST_J_MP,
        ST_J_MV,
        ST_J_MA,
        ST_J_AX,
        ST_CM_MUL,
        ST_CM_DIV,
        ST_CM_WAIT,
        ST_J_OUT
    } state_t;

    // Which scaled division is in flight for the current joint.
    typedef enum logic [1:0] {
        PH_VEL,
        PH_ACC1,
        PH_ACC2
    } phase_t;

    // Clamp a signed value to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Arithmetic right shift rounding to nearest, halves away from zero.
    function automatic logic signed [63:0] rshift_rnd(input logic signed [63:0] v,
                                                      input int sh);
        logic signed [63:0] half;
        logic signed [63:0] t;
        half = 64'sd1 <<< (sh - 1);
        t = v + half - $signed({63'd0, v[63]});
        return t >>> sh;
    endfunction

endpackage

`default_nettype wire

/* hdl/quintic_joint_trajectory_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     func, joint_index, start_angle,
//                                              target_angle, sim_time_us
// out       output     out_valid / out_ready   joint_number, position, velocity,
//                                              acceleration, finished, last
// cfg       input      cfg_wen                 cfg_addr, cfg_wdata
//
// A load item is bound by one division.
// A tick item uses one division for the time fraction and three per joint,
// all on the single shared divider. Once the move has finished the time
// division is skipped.
// in_ready is high only while idle; each result waits in its register until
// taken, and the sequencer holds while out_ready is low.
// Reset is asynchronous and clears all control state; joint stores are not.
module quintic_joint_trajectory_core
    import qjt_pkg::*;
#(
    parameter int MAX_JOINTS = MAX_JOINTS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               func,
    input  wire logic [2:0]         joint_index,
    input  wire logic signed [31:0] start_angle,
    input  wire logic signed [31:0] target_angle,
    input  wire logic [39:0]        sim_time_us,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              joint_number,
    output logic signed [31:0]      position,
    output logic signed [31:0]      velocity,
    output logic signed [31:0]      acceleration,
    output logic                    finished,
    output logic                    last,
    input  wire logic               cfg_wen,
    input  wire logic [0:0]         cfg_addr,
    input  wire logic [16:0]        cfg_wdata
);

    localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int CW = $clog2(MAX_JOINTS + 1);

    state_t state_reg, state_next;
    phase_t phase_reg;

    // Control state.
    logic [16:0]        ratio_reg;
    logic [3:0]         jcnt_reg;
    logic [32:0]        max_disp_reg;
    logic [24:0]        dur_reg;
    logic [24:0]        elapsed_reg;
    logic [39:0]        prev_time_reg;
    logic               time_seen_reg;
    logic [JW-1:0]      k_reg;

    // Payload state.
    logic signed [31:0] start_mem [MAX_JOINTS];
    logic signed [31:0] target_mem [MAX_JOINTS];
    logic signed [40:0] dt_reg;
    logic               fin_reg;
    logic [CW-1:0]      n_reg;
    logic [29:0]        tau_reg;
    logic [29:0]        p2_reg;
    logic [29:0]        p3_reg;
    logic [29:0]        p4_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] sd_reg;
    logic signed [31:0] sdd_reg;
    logic signed [31:0] st_rd_reg;
    logic signed [31:0] tg_rd_reg;
    logic signed [32:0] delta_reg;
    logic signed [65:0] prod_reg;
    logic signed [33:0] rp_reg;
    logic signed [47:0] vel_x_reg;
    logic signed [47:0] acc_x_reg;
    logic signed [63:0] cm_reg;
    logic               sgn_reg;
    logic signed [31:0] pos_reg;
    logic signed [31:0] vel_reg;
    logic signed [31:0] acc_reg;

    // Combinational signals.
    logic               in_acc;
    logic               idx_ok;
    logic               ld_ok;
    logic signed [32:0] ld_diff;
    logic [32:0]        ld_disp;
    logic [39:0]        prev_sel;
    logic [16:0]        step;
    logic [25:0]        esum;
    logic [24:0]        elapsed_next;
    logic               fin_next;
    logic [16:0]        ratio_cl;
    logic [CW-1:0]      n_next;
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;
    logic               div_start;
    logic               div_done;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIVS_W-1:0]  div_divisor;
    logic [DIV_W-1:0]   div_q;
    logic signed [63:0] half_t;
    logic signed [63:0] div_res;
    logic [24:0]        dur_cl;
    logic signed [39:0] s_raw;
    logic signed [39:0] sd_raw;
    logic signed [39:0] sdd_raw;
    logic signed [39:0] sdd_rnd;
    logic [29:0]        p5;
    logic signed [47:0] cm_x;
    logic signed [63:0] pos_sum;
    logic               out_last;

    // Input handshake and load decode.
    always_comb
    begin
        in_acc  = in_valid && in_ready;
        idx_ok  = ({29'd0, joint_index} < MAX_JOINTS);
        ld_ok   = in_acc && !func && idx_ok;
        ld_diff = $signed({target_angle[31], target_angle})
                - $signed({start_angle[31], start_angle});
        ld_disp = ld_diff[32] ? 33'(-ld_diff) : 33'(ld_diff);
        prev_sel = time_seen_reg ? prev_time_reg : sim_time_us;
    end

    // Elapsed time update from the latched step.
    always_comb
    begin
        if (dt_reg > 41'sd0 && dt_reg < 41'(STEP_MAX_US))
            step = dt_reg[16:0];
        else if (dt_reg <= 41'sd0)
            step = STEP_DEF_US;
        else
            step = '0;
        esum = {1'b0, elapsed_reg} + {9'd0, step};
        elapsed_next = (esum > {1'b0, dur_reg}) ? dur_reg : esum[24:0];
        fin_next = (elapsed_next >= dur_reg);
    end

    // Speed ratio and joint count as used.
    always_comb
    begin
        if (ratio_reg < RATIO_MIN)
            ratio_cl = RATIO_MIN;
        else if (ratio_reg > RATIO_MAX)
            ratio_cl = RATIO_MAX;
        else
            ratio_cl = ratio_reg;
        if (jcnt_reg == 4'd0)
            n_next = CW'(1);
        else if (int'(jcnt_reg) > MAX_JOINTS)
            n_next = CW'(MAX_JOINTS);
        else
            n_next = CW'(jcnt_reg);
    end

    // Quintic coefficients from the powers of the time fraction.
    always_comb
    begin
        p5      = prod_reg[59:30];
        s_raw   = $signed(40'(p3_reg) * 40'd10 - 40'(p4_reg) * 40'd15
                + 40'(p5) * 40'd6);
        sd_raw  = $signed(40'(p2_reg) * 40'd30 - 40'(p3_reg) * 40'd60
                + 40'(p4_reg) * 40'd30);
        sdd_raw = $signed(40'(tau_reg) * 40'd60 - 40'(p2_reg) * 40'd180
                + 40'(p3_reg) * 40'd120);
        sdd_rnd = (sdd_raw + 40'sd2 - $signed({39'd0, sdd_raw[39]})) >>> 2;
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LD_MUL:
            begin
                mul_a = $signed({1'b0, max_disp_reg});
                mul_b = US_PER_S;
            end
            ST_TK_P2:
            begin
                mul_a = $signed({4'd0, tau_reg});
                mul_b = $signed({2'd0, tau_reg});
            end
            ST_TK_P3, ST_TK_P4, ST_TK_P5:
            begin
                mul_a = $signed({4'd0, prod_reg[59:30]});
                mul_b = $signed({2'd0, tau_reg});
            end
            ST_J_MP:
            begin
                mul_a = {delta_reg[32], delta_reg};
                mul_b = s_reg;
            end
            ST_J_MV:
            begin
                mul_a = {delta_reg[32], delta_reg};
                mul_b = sd_reg;
            end
            ST_J_MA:
            begin
                mul_a = {delta_reg[32], delta_reg};
                mul_b = sdd_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider operand selection and result sign handling.
    always_comb
    begin
        half_t = $signed({40'd0, dur_reg[24:1]});
        div_start = (state_reg == ST_LD_DIV) || (state_reg == ST_TK_DIV)
                 || (state_reg == ST_CM_DIV);
        case (state_reg)
            ST_LD_DIV:
            begin
                div_dividend = prod_reg[63:0];
                div_divisor  = {ratio_cl, 8'd0};
            end
            ST_TK_DIV:
            begin
                div_dividend = {9'd0, elapsed_reg, 30'd0};
                div_divisor  = dur_reg;
            end
            default:
            begin
                div_dividend = cm_reg[63] ? 64'(half_t - cm_reg) : 64'(cm_reg + half_t);
                div_divisor  = dur_reg;
            end
        endcase
        div_res = sgn_reg ? -$signed(div_q) : $signed(div_q);
        if (div_q < 64'(DUR_MIN_US))
            dur_cl = DUR_MIN_US;
        else if (div_q > 64'(DUR_MAX_US))
            dur_cl = DUR_MAX_US;
        else
            dur_cl = div_q[24:0];
        cm_x = (phase_reg == PH_VEL) ? vel_x_reg : acc_x_reg;
        pos_sum = 64'(st_rd_reg) + 64'(rp_reg);
        out_last = (CW'(k_reg) + CW'(1) == n_reg);
    end

    qjt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and handshake outputs.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (func)
                        state_next = ST_TK_STEP;
                    else if (idx_ok)
                        state_next = ST_LD_MUL;
                end
            end
            ST_LD_MUL:  state_next = ST_LD_DIV;
            ST_LD_DIV:  state_next = ST_LD_WAIT;
            ST_LD_WAIT: if (div_done) state_next = ST_IDLE;
            ST_TK_STEP: state_next = fin_next ? ST_J_RD : ST_TK_DIV;
            ST_TK_DIV:  state_next = ST_TK_WAIT;
            ST_TK_WAIT: if (div_done) state_next = ST_TK_P2;
            ST_TK_P2:   state_next = ST_TK_P3;
            ST_TK_P3:   state_next = ST_TK_P4;
            ST_TK_P4:   state_next = ST_TK_P5;
            ST_TK_P5:   state_next = ST_TK_POLY;
            ST_TK_POLY: state_next = ST_J_RD;
            ST_J_RD:    state_next = ST_J_DELTA;
            ST_J_DELTA: state_next = ST_J_MP;
            ST_J_MP:    state_next = ST_J_MV;
            ST_J_MV:    state_next = ST_J_MA;
            ST_J_MA:    state_next = ST_J_AX;
            ST_J_AX:    state_next = ST_CM_MUL;
            ST_CM_MUL:  state_next = ST_CM_DIV;
            ST_CM_DIV:  state_next = ST_CM_WAIT;
            ST_CM_WAIT:
            begin
                if (div_done)
                    state_next = (phase_reg == PH_ACC2) ? ST_J_OUT : ST_CM_MUL;
            end
            ST_J_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = out_last ? ST_IDLE : ST_J_RD;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control registers: configuration, move timing, joint counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg     <= RATIO_RESET;
            jcnt_reg      <= JCNT_RESET;
            max_disp_reg  <= '0;
            dur_reg       <= DUR_RESET_US;
            elapsed_reg   <= '0;
            prev_time_reg <= '0;
            time_seen_reg <= 1'b0;
            k_reg         <= '0;
            phase_reg     <= PH_VEL;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_SPEED_RATIO: ratio_reg <= cfg_wdata;
                    REG_JOINT_COUNT: jcnt_reg  <= cfg_wdata[3:0];
                    default:         ratio_reg <= ratio_reg;
                endcase
            end
            if (ld_ok)
            begin
                if (joint_index == 3'd0 || ld_disp > max_disp_reg)
                    max_disp_reg <= ld_disp;
                elapsed_reg   <= '0;
                time_seen_reg <= 1'b0;
            end
            if (in_acc && func)
            begin
                prev_time_reg <= sim_time_us;
                time_seen_reg <= 1'b1;
            end
            if (state_reg == ST_LD_WAIT && div_done)
                dur_reg <= dur_cl;
            if (state_reg == ST_TK_STEP)
            begin
                elapsed_reg <= elapsed_next;
                k_reg       <= '0;
            end
            if (state_reg == ST_J_OUT && out_ready && !out_last)
                k_reg <= k_reg + JW'(1);
            if (state_reg == ST_J_AX)
                phase_reg <= PH_VEL;
            if (state_reg == ST_CM_WAIT && div_done)
            begin
                case (phase_reg)
                    PH_VEL:  phase_reg <= PH_ACC1;
                    PH_ACC1: phase_reg <= PH_ACC2;
                    default: phase_reg <= PH_ACC2;
                endcase
            end
        end
    end

    // Joint stores: written on a load, read one joint at a time.
    always_ff @(posedge clk)
    begin
        if (ld_ok)
        begin
            start_mem[JW'(joint_index)]  <= start_angle;
            target_mem[JW'(joint_index)] <= target_angle;
        end
        if (state_reg == ST_J_RD)
        begin
            st_rd_reg <= start_mem[k_reg];
            tg_rd_reg <= target_mem[k_reg];
        end
    end

    // Shared multiplier with its output register.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Datapath registers advanced by the sequencer.
    always_ff @(posedge clk)
    begin
        if (in_acc && func)
            dt_reg <= $signed({1'b0, sim_time_us}) - $signed({1'b0, prev_sel});
        case (state_reg)
            ST_TK_STEP:
            begin
                fin_reg <= fin_next;
                n_reg   <= n_next;
                s_reg   <= ONE_Q30;
                sd_reg  <= '0;
                sdd_reg <= '0;
            end
            ST_TK_WAIT:
            begin
                if (div_done)
                    tau_reg <= div_q[29:0];
            end
            ST_TK_P3: p2_reg <= prod_reg[59:30];
            ST_TK_P4: p3_reg <= prod_reg[59:30];
            ST_TK_P5: p4_reg <= prod_reg[59:30];
            ST_TK_POLY:
            begin
                s_reg   <= s_raw[31:0];
                sd_reg  <= sd_raw[31:0];
                sdd_reg <= sdd_rnd[31:0];
            end
            ST_J_DELTA:
                delta_reg <= $signed({tg_rd_reg[31], tg_rd_reg})
                           - $signed({st_rd_reg[31], st_rd_reg});
            ST_J_MV: rp_reg    <= 34'(rshift_rnd(prod_reg[63:0], 30));
            ST_J_MA: vel_x_reg <= 48'(rshift_rnd(prod_reg[63:0], 24));
            ST_J_AX:
            begin
                acc_x_reg <= 48'(rshift_rnd(prod_reg[63:0], 20));
                pos_reg   <= sat32(pos_sum);
            end
            ST_CM_MUL: cm_reg  <= cm_x * CM_K;
            ST_CM_DIV: sgn_reg <= cm_reg[63];
            ST_CM_WAIT:
            begin
                if (div_done)
                begin
                    case (phase_reg)
                        PH_VEL:  vel_reg   <= sat32(div_res);
                        PH_ACC1: acc_x_reg <= div_res[47:0];
                        default: acc_reg   <= sat32(div_res);
                    endcase
                end
            end
            default:
            begin
                sgn_reg <= sgn_reg;
            end
        endcase
    end

    // Result item fields.
    assign joint_number = 3'(k_reg);
    assign position     = pos_reg;
    assign velocity     = vel_reg;
    assign acceleration = acc_reg;
    assign finished     = fin_reg;
    assign last         = out_last;

    // The block never offers a result while it can take an item.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready and out_valid high together");

    // Elapsed time is capped at the move duration.
    a_elapsed_cap: assert property (@(posedge clk) disable iff (!rst_n)
        elapsed_reg <= dur_reg)
        else $error("elapsed time beyond move duration");

    // Duration stays within its clamp limits.
    a_dur_range: assert property (@(posedge clk) disable iff (!rst_n)
        (dur_reg >= DUR_MIN_US) && (dur_reg <= DUR_MAX_US))
        else $error("move duration out of range");

    // Taking the final joint of a tick returns the block to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("not idle after final joint");

endmodule

`default_nettype wire

/* hdl/qjt_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle.
module qjt_div
    import qjt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DIV_W-1:0]    dividend,
    input  wire logic [DIVS_W-1:0]   divisor,
    output logic                     done,
    output logic [DIV_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  q_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [DIVS_W:0]   trial;
    logic              fits;

    // Shift in the next dividend bit and test against the divisor.
    always_comb
    begin
        trial = {rem_reg, q_reg[DIV_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    // Control: iteration counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(DIV_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            q_reg   <= {q_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? DIVS_W'(trial - {1'b0, dvs_reg}) : trial[DIVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire
